// ===== design/mjdc_pkg.sv =====
// mjdc_pkg: transaction types, operation codes, scaled calendar constants and
// lookup tables for the MJD calendar converter. No dependencies.
package mjdc_pkg;

    // Operation codes carried in the action field
    localparam logic [1:0] ACT_DATE_TO_MJD = 2'd0;
    localparam logic [1:0] ACT_MJD_TO_DATE = 2'd1;
    localparam logic [1:0] ACT_MJD_TO_DOY  = 2'd2;

    // Registers from the accepted command to the path outputs
    localparam int PIPE_DEPTH = 8;
    // Compute stages in the date-to-MJD path; the rest is a delay line
    localparam int D2M_STAGES = 4;
    localparam int D2M_PAD    = PIPE_DEPTH - D2M_STAGES;

    // Documented input ranges
    localparam int MJD_MAX  = 99999;
    localparam int YEAR_MIN = 1858;
    localparam int YEAR_MAX = 2132;

    // Date to MJD: sum of the floor terms minus (2400001 - 1720997)
    localparam int MJD_OFS     = 2400001 - 1720997;
    localparam int MJD_SUM_MAX = MJD_OFS + MJD_MAX;

    // Century term: floor((jd - 1684594.75) / 36524.25), numerator and divisor scaled by 4,
    // becomes floor((4 * mjd + Q_X_OFS) / Q_DIV), which lies in 19..22
    localparam int Q_X_OFS = 2861625;
    localparam int Q_DIV   = 146097;
    localparam int Q_BASE  = 19;
    // jd - 1721120 with jd = mjd + 2400001
    localparam int N_OFS   = 2400001 - 1721120;

    // Year split: floor((4n + 3) / 1461) by reciprocal, one correction step
    localparam int YR_DIV   = 1461;
    localparam int YR_SHIFT = 22;
    localparam int YR_RECIP = (1 << YR_SHIFT) / YR_DIV;

    // x / 100 for x below 43699 is (x * 5243) >> 19
    localparam int HUND_RECIP = 5243;
    localparam int HUND_SHIFT = 19;

    localparam int DD_BIAS   = 123;
    localparam int WRAP_DAYS = 429;

    // floor(30.61 * t) for t = 0..15
    localparam logic [8:0] MON_FLOOR [16] = '{
        9'd0,   9'd30,  9'd61,  9'd91,  9'd122, 9'd153, 9'd183, 9'd214,
        9'd244, 9'd275, 9'd306, 9'd336, 9'd367, 9'd397, 9'd428, 9'd459
    };

    // ceil(30.61 * t) for t = 1..15: the smallest dd that gives t
    localparam logic [8:0] MON_CEIL [15] = '{
        9'd31,  9'd62,  9'd92,  9'd123, 9'd154, 9'd184, 9'd215, 9'd245,
        9'd276, 9'd307, 9'd337, 9'd368, 9'd398, 9'd429, 9'd460
    };

    // Days before each month in a common year, padded to the index range
    localparam logic [8:0] DAYS_BEFORE [16] = '{
        9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151, 9'd181, 9'd212,
        9'd243, 9'd273, 9'd304, 9'd334, 9'd0,   9'd0,   9'd0,   9'd0
    };

    typedef struct packed {
        logic [1:0]  action;
        logic [4:0]  day_in;
        logic [3:0]  month_in;
        logic [11:0] year_in;
        logic [16:0] mjd_in;
    } cmd_t;

    typedef struct packed {
        logic [16:0] mjd_out;
        logic [4:0]  day_out;
        logic [3:0]  month_out;
        logic [11:0] year_out;
        logic [8:0]  day_of_year;
        logic        range_error;
    } res_t;

    // Date-to-MJD path result
    typedef struct packed {
        logic        err;
        logic [16:0] mjd;
    } d2m_t;

    // MJD-to-date path result
    typedef struct packed {
        logic        err;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
        logic [8:0]  doy;
    } m2d_t;

endpackage

// ===== design/mjdc_d2m.sv =====
// mjdc_d2m: pipelined date to MJD path, four compute stages plus a delay line
// to the common pipeline depth. Depends on mjdc_pkg.
module mjdc_d2m (
    input  logic           clk,
    input  mjdc_pkg::cmd_t cmd,
    output mjdc_pkg::d2m_t res
);

    // Stage 1: range check, March-based month, month term plus day
    logic        s1_err_next, s1_err_reg;
    logic [11:0] s1_yp_next, s1_yp_reg;
    logic [8:0]  s1_part_next, s1_part_reg;
    logic        f;
    logic [3:0]  mp;

    // Stage 2: year term and century count
    logic        s2_err_reg;
    logic [8:0]  s2_part_reg;
    logic [20:0] s2_term_next, s2_term_reg;
    logic [5:0]  s2_cent_next, s2_cent_reg;
    logic [24:0] cent_prod;

    // Stage 3: full sum
    logic        s3_err_reg;
    logic [20:0] s3_sum_next, s3_sum_reg;
    logic [6:0]  cent_p1;
    logic [7:0]  cent_x3;

    // Stage 4: offset and result range
    mjdc_pkg::d2m_t s4_next, s4_reg;
    mjdc_pkg::d2m_t dly_reg [mjdc_pkg::D2M_PAD];

    always_comb
    begin
        f = (cmd.month_in <= 4'd2);
        s1_err_next = (cmd.day_in == 5'd0) || (cmd.month_in == 4'd0)
                   || (cmd.month_in > 4'd12)
                   || (cmd.year_in < 12'(mjdc_pkg::YEAR_MIN))
                   || (cmd.year_in > 12'(mjdc_pkg::YEAR_MAX));
        mp = cmd.month_in + 4'd1 + (f ? 4'd12 : 4'd0);
        s1_yp_next = cmd.year_in - {11'd0, f};
        s1_part_next = mjdc_pkg::MON_FLOOR[mp] + {4'd0, cmd.day_in};
    end

    always_comb
    begin
        // floor(365.25 * yp) = 365 * yp + yp / 4
        s2_term_next = 21'(s1_yp_reg) * 21'd365 + {11'd0, s1_yp_reg[11:2]};
        cent_prod = 25'(s1_yp_reg) * 25'(mjdc_pkg::HUND_RECIP);
        s2_cent_next = cent_prod[mjdc_pkg::HUND_SHIFT +: 6];
    end

    always_comb
    begin
        cent_p1 = {1'b0, s2_cent_reg} + 7'd1;
        cent_x3 = {1'b0, cent_p1} + {cent_p1, 1'b0};
        s3_sum_next = {12'd0, s2_part_reg} + s2_term_reg - {15'd0, cent_x3[7:2]};
    end

    always_comb
    begin
        s4_next.err = s3_err_reg
                   || (s3_sum_reg < 21'(mjdc_pkg::MJD_OFS))
                   || (s3_sum_reg > 21'(mjdc_pkg::MJD_SUM_MAX));
        s4_next.mjd = 17'(s3_sum_reg - 21'(mjdc_pkg::MJD_OFS));
    end

    always_ff @(posedge clk)
    begin
        s1_err_reg  <= s1_err_next;
        s1_yp_reg   <= s1_yp_next;
        s1_part_reg <= s1_part_next;
        s2_err_reg  <= s1_err_reg;
        s2_part_reg <= s1_part_reg;
        s2_term_reg <= s2_term_next;
        s2_cent_reg <= s2_cent_next;
        s3_err_reg  <= s2_err_reg;
        s3_sum_reg  <= s3_sum_next;
        s4_reg      <= s4_next;
        dly_reg[0]  <= s4_reg;
        for (int i = 1; i < mjdc_pkg::D2M_PAD; i++)
        begin
            dly_reg[i] <= dly_reg[i-1];
        end
    end

    assign res = dly_reg[mjdc_pkg::D2M_PAD-1];

endmodule

// ===== design/mjdc_m2d.sv =====
// mjdc_m2d: pipelined MJD to Gregorian date and ordinal day path, eight stages.
// Depends on mjdc_pkg.
module mjdc_m2d (
    input  logic           clk,
    input  mjdc_pkg::cmd_t cmd,
    output mjdc_pkg::m2d_t res
);

    // Stage 1: century correction, day count from the March-based epoch
    logic [21:0] x;
    logic [4:0]  q;
    logic [6:0]  q3;
    logic        s1_err_next;
    logic [19:0] s1_n_next;
    logic        s1_err_reg;
    logic [19:0] s1_n_reg;

    // Stage 2: reciprocal multiply for the year estimate
    logic [21:0] w2;
    logic [33:0] yr_prod;
    logic [11:0] s2_aest_next;
    logic        s2_err_reg;
    logic [19:0] s2_n_reg;
    logic [11:0] s2_aest_reg;

    // Stage 3: remainder check
    logic [21:0] w3;
    logic [21:0] rem;
    logic        s3_ge_next;
    logic        s3_err_reg;
    logic [19:0] s3_n_reg;
    logic [11:0] s3_aest_reg;
    logic        s3_ge_reg;

    // Stage 4: corrected year count
    logic        s4_err_reg;
    logic [19:0] s4_n_reg;
    logic [11:0] s4_a_reg;

    // Stage 5: day within the March-based year
    logic [20:0] yr_days;
    logic [20:0] dd_full;
    logic [8:0]  s5_dd_next;
    logic        s5_err_reg;
    logic [8:0]  s5_dd_reg;
    logic [11:0] s5_a_reg;

    // Stage 6: month count and year wrap
    logic [3:0]  s6_t_next;
    logic        s6_wrap_next;
    logic        s6_err_reg;
    logic [8:0]  s6_dd_reg;
    logic [3:0]  s6_t_reg;
    logic        s6_wrap_reg;
    logic [11:0] s6_y_reg;

    // Stage 7: day, month, century of year
    logic [8:0]  d_full;
    logic [24:0] hq_prod;
    logic        s7_err_reg;
    logic [4:0]  s7_d_reg;
    logic [3:0]  s7_m_reg;
    logic [11:0] s7_y_reg;
    logic [5:0]  s7_hq_reg;

    // Stage 8: leap year and ordinal day
    logic [12:0] y100;
    logic        leap;
    logic [3:0]  mi;
    mjdc_pkg::m2d_t s8_next, s8_reg;

    always_comb
    begin
        x = {3'd0, cmd.mjd_in, 2'd0} + 22'(mjdc_pkg::Q_X_OFS);
        q = 5'(mjdc_pkg::Q_BASE)
          + {4'd0, (x >= 22'(mjdc_pkg::Q_DIV * 20))}
          + {4'd0, (x >= 22'(mjdc_pkg::Q_DIV * 21))}
          + {4'd0, (x >= 22'(mjdc_pkg::Q_DIV * 22))};
        q3 = {2'd0, q} + {1'b0, q, 1'b0};
        s1_err_next = (cmd.mjd_in > 17'(mjdc_pkg::MJD_MAX));
        s1_n_next = {3'd0, cmd.mjd_in} + 20'(mjdc_pkg::N_OFS) + {15'd0, q3[6:2]};
    end

    always_comb
    begin
        w2 = {s1_n_reg, 2'b11};
        yr_prod = 34'(w2) * 34'(mjdc_pkg::YR_RECIP);
        s2_aest_next = yr_prod[mjdc_pkg::YR_SHIFT +: 12];
    end

    always_comb
    begin
        w3 = {s2_n_reg, 2'b11};
        rem = w3 - 22'(22'(s2_aest_reg) * 22'(mjdc_pkg::YR_DIV));
        s3_ge_next = (rem >= 22'(mjdc_pkg::YR_DIV));
    end

    always_comb
    begin
        // floor(365.25 * a) = 365 * a + a / 4
        yr_days = 21'(s4_a_reg) * 21'd365 + {11'd0, s4_a_reg[11:2]};
        dd_full = {1'b0, s4_n_reg} + 21'(mjdc_pkg::DD_BIAS) - yr_days;
        s5_dd_next = dd_full[8:0];
    end

    always_comb
    begin
        s6_t_next = 4'd0;
        for (int i = 0; i < 15; i++)
        begin
            s6_t_next = s6_t_next + {3'd0, (s5_dd_reg >= mjdc_pkg::MON_CEIL[i])};
        end
        s6_wrap_next = (s5_dd_reg >= 9'(mjdc_pkg::WRAP_DAYS));
    end

    always_comb
    begin
        d_full = s6_dd_reg - mjdc_pkg::MON_FLOOR[s6_t_reg];
        hq_prod = 25'(s6_y_reg) * 25'(mjdc_pkg::HUND_RECIP);
    end

    always_comb
    begin
        y100 = 13'(s7_hq_reg) * 13'd100;
        // Divisible by 4, and not a century year unless the century is too
        leap = (s7_y_reg[1:0] == 2'b00)
            && ((y100 != {1'b0, s7_y_reg}) || (s7_hq_reg[1:0] == 2'b00));
        mi = s7_m_reg - 4'd1;
        s8_next.err = s7_err_reg;
        s8_next.day = s7_d_reg;
        s8_next.month = s7_m_reg;
        s8_next.year = s7_y_reg;
        s8_next.doy = mjdc_pkg::DAYS_BEFORE[mi] + {4'd0, s7_d_reg}
                    + {8'd0, (leap && (mi >= 4'd2))};
    end

    always_ff @(posedge clk)
    begin
        s1_err_reg  <= s1_err_next;
        s1_n_reg    <= s1_n_next;
        s2_err_reg  <= s1_err_reg;
        s2_n_reg    <= s1_n_reg;
        s2_aest_reg <= s2_aest_next;
        s3_err_reg  <= s2_err_reg;
        s3_n_reg    <= s2_n_reg;
        s3_aest_reg <= s2_aest_reg;
        s3_ge_reg   <= s3_ge_next;
        s4_err_reg  <= s3_err_reg;
        s4_n_reg    <= s3_n_reg;
        s4_a_reg    <= s3_aest_reg + {11'd0, s3_ge_reg};
        s5_err_reg  <= s4_err_reg;
        s5_dd_reg   <= s5_dd_next;
        s5_a_reg    <= s4_a_reg;
        s6_err_reg  <= s5_err_reg;
        s6_dd_reg   <= s5_dd_reg;
        s6_t_reg    <= s6_t_next;
        s6_wrap_reg <= s6_wrap_next;
        s6_y_reg    <= s5_a_reg + {11'd0, s6_wrap_next};
        s7_err_reg  <= s6_err_reg;
        s7_d_reg    <= d_full[4:0];
        s7_m_reg    <= s6_t_reg - 4'd1 - (s6_wrap_reg ? 4'd12 : 4'd0);
        s7_y_reg    <= s6_y_reg;
        s7_hq_reg   <= hq_prod[mjdc_pkg::HUND_SHIFT +: 6];
        s8_reg      <= s8_next;
    end

    assign res = s8_reg;

endmodule

// ===== design/mjd_calendar_converter_top.sv =====
// mjd_calendar_converter_top: top level of the MJD calendar converter.
// Depends on mjdc_pkg, mjdc_d2m and mjdc_m2d.
//
//   channel  | handshake          | payload           | direction
//   ---------+--------------------+-------------------+----------
//   command  | start, busy        | cmd    (cmd_t)    | in
//   result   | done (one strobe)  | result (res_t)    | out
//
// Throughput is one transaction per clock; busy is held low since nothing
// in the datapath ever waits. A result passes through eight register stages
// in the MJD-to-date path (the year split needs a multiply, a remainder
// multiply and a correction in turn) plus the output register. The
// date-to-MJD path finishes in four stages and is delayed to match.
// Reset clears only the valid line and done; payload registers are free.
// The receiver cannot stall, so every result is shown for exactly one cycle.
module mjd_calendar_converter_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  mjdc_pkg::cmd_t cmd,
    output logic           done,
    output mjdc_pkg::res_t result
);

    mjdc_pkg::d2m_t d2m_res;
    mjdc_pkg::m2d_t m2d_res;

    // Valid bits and operation codes travel alongside the two paths
    logic [mjdc_pkg::PIPE_DEPTH-1:0] valid_reg;
    logic [1:0]                      act_reg [mjdc_pkg::PIPE_DEPTH];
    logic [1:0]                      act_last;

    logic           done_reg;
    mjdc_pkg::res_t result_next, result_reg;

    // Both paths see every command; the action code picks the result at the end
    mjdc_d2m u_d2m (
        .clk (clk),
        .cmd (cmd),
        .res (d2m_res)
    );

    mjdc_m2d u_m2d (
        .clk (clk),
        .cmd (cmd),
        .res (m2d_res)
    );

    // Advance the valid line every cycle; a transaction enters on start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= {valid_reg[mjdc_pkg::PIPE_DEPTH-2:0], start & ~busy};
            done_reg  <= valid_reg[mjdc_pkg::PIPE_DEPTH-1];
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg[0] <= cmd.action;
        for (int i = 1; i < mjdc_pkg::PIPE_DEPTH; i++)
        begin
            act_reg[i] <= act_reg[i-1];
        end
        result_reg <= result_next;
    end

    assign act_last = act_reg[mjdc_pkg::PIPE_DEPTH-1];

    // Select the path result and drop every field on a range error
    always_comb
    begin
        result_next = '0;
        case (act_last)
            mjdc_pkg::ACT_DATE_TO_MJD:
            begin
                result_next.range_error = d2m_res.err;
                if (!d2m_res.err)
                begin
                    result_next.mjd_out = d2m_res.mjd;
                end
            end
            mjdc_pkg::ACT_MJD_TO_DATE:
            begin
                result_next.range_error = m2d_res.err;
                if (!m2d_res.err)
                begin
                    result_next.day_out   = m2d_res.day;
                    result_next.month_out = m2d_res.month;
                    result_next.year_out  = m2d_res.year;
                end
            end
            mjdc_pkg::ACT_MJD_TO_DOY:
            begin
                result_next.range_error = m2d_res.err;
                if (!m2d_res.err)
                begin
                    result_next.year_out    = m2d_res.year;
                    result_next.day_of_year = m2d_res.doy;
                end
            end
            default:
            begin
                // Unused action code
                result_next.range_error = 1'b1;
            end
        endcase
    end

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== tb/sv/mjd_calendar_converter_top_tb.sv =====
// mjd_calendar_converter_top_tb: self-checking testbench for the MJD calendar
// converter. Depends on mjdc_pkg and mjd_calendar_converter_top.
module mjd_calendar_converter_top_tb;

    // The selector value that has no operation behind it
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // Julian Day numbers used by the calendar formulas
    localparam longint JD_AT_MJD0   = 2400001;   // JD of MJD 0, as the formulas count it
    localparam longint JD_CAL_BASE  = 1720997;   // date-to-JD offset
    localparam longint JD_YEAR_BASE = 1721120;   // day count origin for the year split
    localparam longint CENT_OFS_X100 = 168459475; // 1684594.75 in hundredths
    localparam longint CENT_LEN_X100 = 3652425;   // 36524.25 in hundredths

    // Cycles with no transaction in either direction before the run is declared hung
    localparam int QUIET_LIMIT = 1000;
    // Cycles to keep watching after the last result: latency plus margin
    localparam int TAIL_CYCLES = 12;
    localparam int PHASE_ITEMS = 400;

    localparam mjdc_pkg::res_t RANGE_ERR = '{17'd0, 5'd0, 4'd0, 12'd0, 9'd0, 1'b1};

    typedef struct {
        mjdc_pkg::cmd_t c;
        bit             typed;
        mjdc_pkg::res_t r;
    } stim_row_t;

    logic           clk   = 1'b0;
    logic           rst_n = 1'b0;
    logic           start = 1'b0;
    mjdc_pkg::cmd_t cmd   = '0;
    logic           busy;
    logic           done;
    mjdc_pkg::res_t result;

    // Expectation that travels with the command: a typed-in result or none
    logic           next_typed  = 1'b0;
    mjdc_pkg::res_t next_expect = '0;

    mjdc_pkg::res_t expected_results[$];
    stim_row_t      stim_table[$];
    mjdc_pkg::res_t oldest;

    int unsigned days_before_month_tbl[12] = '{
        0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
    };

    int quiet_cycles = 0;
    int fail_count   = 0;
    int results_seen = 0;
    int range_errors = 0;
    int by_action[4] = '{0, 0, 0, 0};

    mjd_calendar_converter_top u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Compute the conversion result for one command, field for field.
    function automatic mjdc_pkg::res_t convert_calendar(input mjdc_pkg::cmd_t c);
        mjdc_pkg::res_t r;
        longint dy, mo, yr, mjd;
        longint f, mp, yp, v;
        longint jd, q, k, n, a, dd, wrap, t, yy, mm, dm, mi, doy;
        r   = '0;
        dy  = c.day_in;
        mo  = c.month_in;
        yr  = c.year_in;
        mjd = c.mjd_in;
        case (c.action)
            mjdc_pkg::ACT_DATE_TO_MJD:
            begin
                if (dy < 1 || mo < 1 || mo > 12
                    || yr < mjdc_pkg::YEAR_MIN || yr > mjdc_pkg::YEAR_MAX)
                    r.range_error = 1'b1;
                else
                begin
                    // January and February count as months 13 and 14 of the year before
                    f  = (mo <= 2) ? 1 : 0;
                    mp = mo + 1 + 12 * f;
                    yp = yr - f;
                    v  = (mp * 3061) / 100 + dy + (yp * 36525) / 100
                       - (((yp / 100) + 1) * 3) / 4 + JD_CAL_BASE - JD_AT_MJD0;
                    if (v < 0 || v > mjdc_pkg::MJD_MAX)
                        r.range_error = 1'b1;
                    else
                        r.mjd_out = 17'(v);
                end
            end
            mjdc_pkg::ACT_MJD_TO_DATE, mjdc_pkg::ACT_MJD_TO_DOY:
            begin
                if (mjd > mjdc_pkg::MJD_MAX)
                    r.range_error = 1'b1;
                else
                begin
                    jd   = mjd + JD_AT_MJD0;
                    q    = (jd * 100 - CENT_OFS_X100) / CENT_LEN_X100;
                    k    = (q * 3) / 4;
                    n    = jd - JD_YEAR_BASE + k;
                    a    = (n * 100 + 90) / 36525;
                    dd   = n - (a * 36525) / 100 + 123;
                    wrap = dd / 429;
                    t    = (dd * 100) / 3061;
                    yy   = a + wrap;
                    mm   = t - 1 - wrap * 12;
                    dm   = dd - (t * 3061) / 100;
                    r.year_out = 12'(yy);
                    if (c.action == mjdc_pkg::ACT_MJD_TO_DATE)
                    begin
                        r.day_out   = 5'(dm);
                        r.month_out = 4'(mm);
                    end
                    else
                    begin
                        mi  = (mm - 1) % 12;
                        doy = days_before_month_tbl[mi] + dm;
                        if (mi >= 2 && (yy % 4 == 0) && ((yy % 100 != 0) || (yy % 400 == 0)))
                            doy = doy + 1;
                        r.day_of_year = 9'(doy);
                    end
                end
            end
            default:
                r.range_error = 1'b1;
        endcase
        return r;
    endfunction

    function automatic mjdc_pkg::cmd_t make_cmd(input logic [1:0] act, input int d,
                                                input int m, input int y, input int j);
        mjdc_pkg::cmd_t c;
        c.action   = act;
        c.day_in   = 5'(d);
        c.month_in = 4'(m);
        c.year_in  = 12'(y);
        c.mjd_in   = 17'(j);
        return c;
    endfunction

    function automatic mjdc_pkg::cmd_t noise_cmd();
        mjdc_pkg::cmd_t c;
        c.action   = 2'($urandom_range(3));
        c.day_in   = 5'($urandom_range(31));
        c.month_in = 4'($urandom_range(15));
        c.year_in  = 12'($urandom_range(4095));
        c.mjd_in   = 17'($urandom_range(131071));
        return c;
    endfunction

    // Mostly well-formed commands with random content; the rest is raw noise,
    // which brings in the unused selector and out-of-range fields.
    function automatic mjdc_pkg::cmd_t random_cmd();
        mjdc_pkg::cmd_t c;
        c = noise_cmd();
        if ($urandom_range(99) < 88)
        begin
            c.action = 2'($urandom_range(2));
            if (c.action == mjdc_pkg::ACT_DATE_TO_MJD)
            begin
                c.day_in   = 5'($urandom_range(31, 1));
                c.month_in = 4'($urandom_range(12, 1));
                c.year_in  = 12'($urandom_range(mjdc_pkg::YEAR_MAX, mjdc_pkg::YEAR_MIN));
                // Lean on the first and last years, where the MJD range cuts in
                if ($urandom_range(7) == 0)
                    c.year_in = $urandom_range(1) ? 12'(mjdc_pkg::YEAR_MIN)
                                                  : 12'(mjdc_pkg::YEAR_MAX);
            end
            else
            begin
                case ($urandom_range(9))
                    0: c.mjd_in = 17'($urandom_range(60));
                    1: c.mjd_in = 17'($urandom_range(mjdc_pkg::MJD_MAX,
                                                     mjdc_pkg::MJD_MAX - 60));
                    default: c.mjd_in = 17'($urandom_range(mjdc_pkg::MJD_MAX));
                endcase
            end
        end
        return c;
    endfunction

    // Add a row whose result comes from the predictor.
    task automatic add_checked(input mjdc_pkg::cmd_t c);
        stim_row_t row;
        row.c     = c;
        row.typed = 1'b0;
        row.r     = '0;
        stim_table.push_back(row);
    endtask

    // Add a row whose result is known by inspection.
    task automatic add_fixed(input mjdc_pkg::cmd_t c, input mjdc_pkg::res_t r);
        stim_row_t row;
        row.c     = c;
        row.typed = 1'b1;
        row.r     = r;
        stim_table.push_back(row);
    endtask

    // Issue one transaction. Hold start high across back-to-back transactions;
    // in idle cycles drop start and put noise on the command bus.
    task automatic issue(input mjdc_pkg::cmd_t c, input bit typed, input mjdc_pkg::res_t r,
                         input int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            cmd   <= noise_cmd();
            @(posedge clk);
        end
        start       <= 1'b1;
        cmd         <= c;
        next_typed  <= typed;
        next_expect <= r;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Drop start and hold off until every outstanding result has come back.
    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
    endtask

    task automatic check_field(input string name, input logic [16:0] want,
                               input logic [16:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Sample both sides at the rising edge. Results are checked before the
    // new command is queued; the converter has registered outputs, so a result
    // can never belong to the command accepted at the same edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            quiet_cycles <= ((start && !busy) || done !== 1'b0) ? 0 : quiet_cycles + 1;
            if (done !== 1'b0)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $error("result strobe with no transaction outstanding");
                    fail_count++;
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    check_field("done", 17'(1), 17'(done));
                    check_field("mjd_out", oldest.mjd_out, result.mjd_out);
                    check_field("day_out", 17'(oldest.day_out), 17'(result.day_out));
                    check_field("month_out", 17'(oldest.month_out), 17'(result.month_out));
                    check_field("year_out", 17'(oldest.year_out), 17'(result.year_out));
                    check_field("day_of_year", 17'(oldest.day_of_year),
                                17'(result.day_of_year));
                    check_field("range_error", 17'(oldest.range_error),
                                17'(result.range_error));
                end
            end
            if (start && !busy)
            begin
                by_action[cmd.action]++;
                if (next_typed)
                    expected_results.push_back(next_expect);
                else
                    expected_results.push_back(convert_calendar(cmd));
                if (expected_results[$].range_error)
                    range_errors++;
            end
        end
    end

    // Watchdog: end the run if no transaction moves for too long.
    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        // Extremes and known answers: MJD 0 is 17 November 1858, day 321
        add_fixed(make_cmd(mjdc_pkg::ACT_DATE_TO_MJD, 17, 11, 1858, 0), '0);
        add_fixed(make_cmd(mjdc_pkg::ACT_MJD_TO_DATE, 0, 0, 0, 0),
                  '{17'd0, 5'd17, 4'd11, 12'd1858, 9'd0, 1'b0});
        add_fixed(make_cmd(mjdc_pkg::ACT_MJD_TO_DOY, 0, 0, 0, 0),
                  '{17'd0, 5'd0, 4'd0, 12'd1858, 9'd321, 1'b0});
        add_checked(make_cmd(mjdc_pkg::ACT_MJD_TO_DATE, 31, 15, 4095, mjdc_pkg::MJD_MAX));
        add_checked(make_cmd(mjdc_pkg::ACT_MJD_TO_DOY, 0, 0, 0, mjdc_pkg::MJD_MAX));
        // Out-of-range inputs and the unused selector
        add_fixed(make_cmd(mjdc_pkg::ACT_MJD_TO_DATE, 0, 0, 0, mjdc_pkg::MJD_MAX + 1),
                  RANGE_ERR);
        add_fixed(make_cmd(mjdc_pkg::ACT_MJD_TO_DOY, 31, 15, 4095, 131071), RANGE_ERR);
        add_fixed(make_cmd(ACT_UNUSED, 31, 15, 4095, 131071), RANGE_ERR);
        add_fixed(make_cmd(ACT_UNUSED, 1, 1, 2000, 0), RANGE_ERR);
        add_fixed(make_cmd(mjdc_pkg::ACT_DATE_TO_MJD, 0, 6, 2000, 0), RANGE_ERR);
        add_fixed(make_cmd(mjdc_pkg::ACT_DATE_TO_MJD, 15, 0, 2000, 0), RANGE_ERR);
        add_fixed(make_cmd(mjdc_pkg::ACT_DATE_TO_MJD, 15, 13, 2000, 0), RANGE_ERR);
        add_fixed(make_cmd(mjdc_pkg::ACT_DATE_TO_MJD, 15, 15, 2000, 0), RANGE_ERR);
        add_fixed(make_cmd(mjdc_pkg::ACT_DATE_TO_MJD, 15, 6, mjdc_pkg::YEAR_MIN - 1, 0),
                  RANGE_ERR);
        add_fixed(make_cmd(mjdc_pkg::ACT_DATE_TO_MJD, 15, 6, mjdc_pkg::YEAR_MAX + 1, 0),
                  RANGE_ERR);
        add_fixed(make_cmd(mjdc_pkg::ACT_DATE_TO_MJD, 31, 12, 4095, 131071), RANGE_ERR);
        add_fixed(make_cmd(mjdc_pkg::ACT_DATE_TO_MJD, 1, 1, 0, 0), RANGE_ERR);
        // Valid dates whose MJD falls below zero or above the maximum, and one close to it
        add_fixed(make_cmd(mjdc_pkg::ACT_DATE_TO_MJD, 1, 1, mjdc_pkg::YEAR_MIN, 0),
                  RANGE_ERR);
        add_fixed(make_cmd(mjdc_pkg::ACT_DATE_TO_MJD, 31, 12, mjdc_pkg::YEAR_MAX, 0),
                  RANGE_ERR);
        add_checked(make_cmd(mjdc_pkg::ACT_DATE_TO_MJD, 31, 8, mjdc_pkg::YEAR_MAX, 0));
        // Day past the end of the month rolls into the next; leap days
        add_checked(make_cmd(mjdc_pkg::ACT_DATE_TO_MJD, 31, 2, 2000, 0));
        add_checked(make_cmd(mjdc_pkg::ACT_DATE_TO_MJD, 29, 2, 2000, 0));
        add_checked(make_cmd(mjdc_pkg::ACT_DATE_TO_MJD, 29, 2, 1900, 0));
        add_checked(make_cmd(mjdc_pkg::ACT_MJD_TO_DOY, 0, 0, 0, 51603));
        add_checked(make_cmd(mjdc_pkg::ACT_MJD_TO_DOY, 0, 0, 0, 51969));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_table[i])
            issue(stim_table[i].c, stim_table[i].typed, stim_table[i].r, 0);
        // Let the pipeline empty completely before the random part
        drain();

        // Sender idle 0%, 55%, 30%, then back to none; the result side has no
        // stall to exercise since done cannot be held off.
        for (int phase = 0; phase < 4; phase++)
        begin
            for (int i = 0; i < PHASE_ITEMS; i++)
                issue(random_cmd(), 1'b0, '0, (phase == 1) ? 55 : (phase == 2) ? 30 : 0);
            drain();
        end

        // Watch for stray strobes after the last expected result
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Converted %0d transactions: %0d date-to-MJD, %0d MJD-to-date,",
                 by_action[0] + by_action[1] + by_action[2] + by_action[3],
                 by_action[0], by_action[1]);
        $display("%0d MJD-to-day-of-year, %0d unused selector; %0d out of range, %0d results",
                 by_action[2], by_action[3], range_errors, results_seen);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== files.f =====
design/mjdc_pkg.sv
design/mjdc_d2m.sv
design/mjdc_m2d.sv
design/mjd_calendar_converter_top.sv
tb/sv/mjd_calendar_converter_top_tb.sv
